/* hw/rtl/layer2_header_parser_macros.svh */
// assertion helpers shared by the checker
`ifndef LAYER2_HEADER_PARSER_MACROS_SVH
`define LAYER2_HEADER_PARSER_MACROS_SVH

// clocked check, quiet while reset is held
`define L2HP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers cycles in reset
`define L2HP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/l2hp_pkg.sv */
`timescale 1ns / 1ps

package l2hp_pkg;

  // link types
  localparam logic [1:0] LINK_ETH  = 2'd0;
  localparam logic [1:0] LINK_WLAN = 2'd1;
  localparam logic [1:0] LINK_NULL = 2'd2;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_BAD_SNAP = 2'd2;

  // layer-3 kind
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_IPV4 = 2'd1;
  localparam logic [1:0] KIND_IPV6 = 2'd2;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] TYPE_MIN   = 16'h0600;

  localparam logic [5:0] ETH_HDR_LEN    = 6'd14;
  localparam logic [5:0] SNAP_HDR_LEN   = 6'd22;
  localparam logic [5:0] WLAN_HDR_LEN   = 6'd24;
  localparam logic [5:0] WLAN_ADDR4_LEN = 6'd6;
  localparam logic [5:0] WLAN_QOS_LEN   = 6'd2;
  localparam logic [5:0] LLC_LEN        = 6'd8;

  // byte positions inside the frame
  localparam logic [5:0] IDX_FIRST      = 6'd0;
  localparam logic [5:0] IDX_FC_HIGH    = 6'd1;
  localparam logic [5:0] IDX_ETH_TYPE   = 6'd13;
  localparam logic [5:0] IDX_SNAP_START = 6'd14;
  localparam logic [5:0] IDX_SNAP_END   = 6'd19;
  localparam logic [5:0] IDX_SNAP_TYPE  = 6'd21;

  localparam logic [1:0] FTYPE_DATA = 2'd2;

  localparam logic [7:0] LLC_SAP_SNAP = 8'hAA;
  localparam logic [7:0] SNAP_CTRL    = 8'h03;
  localparam logic [7:0] LLC_OUI_ZERO = 8'h00;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] base_offset;
    logic [15:0] available_length;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  header_length;
    logic [1:0]  l3_kind;
    logic [15:0] next_offset;
    logic [15:0] remaining_length;
  } result_t;

  typedef struct packed {
    logic [5:0]  byte_index;
    logic        frame_active;
    logic [15:0] control_bits;
    logic [15:0] type_word;
    logic [5:0]  header_target;
    logic        snap_valid;
    logic [15:0] saved_offset;
    logic [15:0] saved_length;
  } state_t;

  localparam state_t STATE_RESET = '{
    byte_index:    6'd0,
    frame_active:  1'b0,
    control_bits:  16'd0,
    type_word:     16'd0,
    header_target: 6'd0,
    snap_valid:    1'b1,
    saved_offset:  16'd0,
    saved_length:  16'd0
  };

  function automatic logic [1:0] kind_of(input logic [15:0] t);
    logic [1:0] k;
    k = KIND_NONE;
    if (t == ETYPE_IPV4) k = KIND_IPV4;
    else if (t == ETYPE_IPV6) k = KIND_IPV6;
    return k;
  endfunction

  // expected LLC/SNAP bytes AA AA 03 00 00 00
  function automatic logic [7:0] snap_byte(input logic [2:0] pos);
    logic [7:0] v;
    case (pos)
      3'd0, 3'd1: v = LLC_SAP_SNAP;
      3'd2:       v = SNAP_CTRL;
      default:    v = LLC_OUI_ZERO;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/l2hp_if.sv */
`timescale 1ns / 1ps

// frame byte requests
interface l2hp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] base_offset;
  logic [15:0] available_length;

  modport source (output valid, data_byte, first_byte, base_offset, available_length,
                  input ready);
  modport sink (input valid, data_byte, first_byte, base_offset, available_length,
                output ready);
endinterface

// per-frame parse results
interface l2hp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  header_length;
  logic [1:0]  l3_kind;
  logic [15:0] next_offset;
  logic [15:0] remaining_length;

  modport source (output valid, status, header_length, l3_kind, next_offset,
                  remaining_length, input ready);
  modport sink (input valid, status, header_length, l3_kind, next_offset,
                remaining_length, output ready);
endinterface

/* hw/rtl/l2hp_step.sv */
`timescale 1ns / 1ps

module l2hp_step (
  input  l2hp_pkg::state_t  st,
  input  logic [1:0]        link_type,
  input  l2hp_pkg::item_t   item,
  output l2hp_pkg::state_t  st_nxt,
  output logic              res_valid,
  output l2hp_pkg::result_t res
);
  import l2hp_pkg::*;

  logic       live;
  logic       give_ok;
  logic       give_fail;
  logic [1:0] fail_code;
  logic [5:0] ok_len;
  logic [1:0] ok_kind;
  logic [5:0] idx;
  logic [6:0] idx_inc;
  logic [15:0] fc;
  logic [5:0] wlan_len;
  logic [5:0] eff_len;

  always_comb begin
    st_nxt = st;
    live   = 1'b0;
    if (item.first_byte) begin
      st_nxt.frame_active  = 1'b1;
      st_nxt.byte_index    = IDX_FIRST;
      st_nxt.saved_offset  = item.base_offset;
      st_nxt.saved_length  = item.available_length;
      st_nxt.snap_valid    = 1'b1;
      st_nxt.type_word     = {8'd0, item.data_byte};
      st_nxt.control_bits  = {8'd0, item.data_byte};
      st_nxt.header_target = 6'd0;
      live = 1'b1;
    end else if (st.frame_active) begin
      st_nxt.byte_index = st.byte_index + 6'd1;
      st_nxt.type_word  = {st.type_word[7:0], item.data_byte};
      live = 1'b1;
    end

    idx     = st_nxt.byte_index;
    idx_inc = {1'b0, idx} + 7'd1;

    // frame control with its second byte in place
    fc = {item.data_byte, st_nxt.control_bits[7:0]};
    wlan_len = WLAN_HDR_LEN;
    if (fc[3:2] == FTYPE_DATA) begin
      if (fc[9:8] == 2'b11) wlan_len = wlan_len + WLAN_ADDR4_LEN;
      if (fc[7]) wlan_len = wlan_len + WLAN_QOS_LEN;
      wlan_len = wlan_len + LLC_LEN;
    end

    give_ok   = 1'b0;
    give_fail = 1'b0;
    fail_code = ST_SHORT;
    ok_len    = 6'd0;
    ok_kind   = KIND_NONE;

    if (live) begin
      case (link_type)
        LINK_NULL: begin
          give_ok = 1'b1;
        end
        LINK_ETH: begin
          if (idx == IDX_FIRST) begin
            if (st_nxt.saved_length < {10'd0, ETH_HDR_LEN}) give_fail = 1'b1;
            else st_nxt.header_target = ETH_HDR_LEN;
          end else if (idx == IDX_ETH_TYPE) begin
            if (st_nxt.type_word >= TYPE_MIN) begin
              give_ok = 1'b1;
              ok_len  = ETH_HDR_LEN;
              ok_kind = kind_of(st_nxt.type_word);
            end else if (st_nxt.saved_length < {10'd0, SNAP_HDR_LEN}) begin
              give_fail = 1'b1;
            end else begin
              st_nxt.header_target = SNAP_HDR_LEN;
            end
          end else if (idx >= IDX_SNAP_START && idx <= IDX_SNAP_END) begin
            if (item.data_byte != snap_byte(3'(idx - IDX_SNAP_START)))
              st_nxt.snap_valid = 1'b0;
          end else if (idx == IDX_SNAP_TYPE) begin
            if (!st_nxt.snap_valid) begin
              give_fail = 1'b1;
              fail_code = ST_BAD_SNAP;
            end else begin
              give_ok = 1'b1;
              ok_len  = SNAP_HDR_LEN;
              ok_kind = kind_of(st_nxt.type_word);
            end
          end
        end
        LINK_WLAN: begin
          if (idx == IDX_FIRST) begin
            if (st_nxt.saved_length < {10'd0, WLAN_HDR_LEN}) give_fail = 1'b1;
            else st_nxt.header_target = WLAN_HDR_LEN;
          end else if (idx == IDX_FC_HIGH) begin
            st_nxt.control_bits = fc;
            if ({10'd0, wlan_len} > st_nxt.saved_length) give_fail = 1'b1;
            else st_nxt.header_target = wlan_len;
          end else if (idx_inc == {1'b0, st_nxt.header_target}) begin
            give_ok = 1'b1;
            ok_len  = st_nxt.header_target;
            if (st_nxt.control_bits[3:2] == FTYPE_DATA)
              ok_kind = kind_of(st_nxt.type_word);
          end
        end
        default: begin
          give_fail = 1'b1;
        end
      endcase
    end

    res_valid = give_ok || give_fail;
    if (res_valid) st_nxt.frame_active = 1'b0;

    eff_len = give_fail ? 6'd0 : ok_len;
    res.status           = give_fail ? fail_code : ST_OK;
    res.header_length    = eff_len;
    res.l3_kind          = give_fail ? KIND_NONE : ok_kind;
    res.next_offset      = st_nxt.saved_offset + {10'd0, eff_len};
    res.remaining_length = st_nxt.saved_length - {10'd0, eff_len};
  end

endmodule

/* hw/rtl/layer2_header_parser.sv */
`timescale 1ns / 1ps
// layer-2 header parser: one frame byte per request, at most one result per frame
// out_valid is registered: it rises as a closing byte leaves the input register
// throughput: 1 byte per cycle, set by the single parse step between the input
//   register and the result register; a closing byte waits while the result stalls
// reset (rst_n low, synchronous): both stages empty, no frame open, link type ethernet

module layer2_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  l2hp_in_if.sink    in_s,
  l2hp_out_if.source out_m
);
  import l2hp_pkg::*;

  // link type register
  logic [1:0] link_type_r;

  // input register: holds one byte request ahead of the parse step
  logic    s1_valid_r;
  item_t   s1_item_r;

  // parser state carried from byte to byte
  state_t  state_r;
  state_t  state_nxt;

  // result register
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;

  logic    step_res_valid;
  result_t step_res;
  logic    advance;
  item_t   in_item;

  assign in_item.data_byte        = in_s.data_byte;
  assign in_item.first_byte       = in_s.first_byte;
  assign in_item.base_offset      = in_s.base_offset;
  assign in_item.available_length = in_s.available_length;

  l2hp_step u_step (
    .st        (state_r),
    .link_type (link_type_r),
    .item      (s1_item_r),
    .st_nxt    (state_nxt),
    .res_valid (step_res_valid),
    .res       (step_res)
  );

  // the held byte moves on unless it makes a result while a full result slot stalls
  assign advance = s1_valid_r && (!step_res_valid || !out_valid_r || out_m.ready);

  // input register refills while a result waits, unless the held byte makes one too
  assign in_s.ready = !s1_valid_r || advance;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && step_res_valid) out_valid_nxt = 1'b1;
    else if (out_m.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= LINK_ETH;
      s1_valid_r  <= 1'b0;
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) link_type_r <= cfg_wdata;
      if (in_s.valid && in_s.ready) s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;
      // state only moves when the held byte is consumed
      if (advance) state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) s1_item_r <= in_item;
    if (advance && step_res_valid) out_res_r <= step_res;
  end

  assign out_m.valid            = out_valid_r;
  assign out_m.status           = out_res_r.status;
  assign out_m.header_length    = out_res_r.header_length;
  assign out_m.l3_kind          = out_res_r.l3_kind;
  assign out_m.next_offset      = out_res_r.next_offset;
  assign out_m.remaining_length = out_res_r.remaining_length;

endmodule

/* hw/rtl/l2hp_checker.sv */
`timescale 1ns / 1ps
`include "layer2_header_parser_macros.svh"

module l2hp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [5:0]  header_length,
  input logic [1:0]  l3_kind,
  input logic [15:0] next_offset
);
  import l2hp_pkg::*;

  `L2HP_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")

  `L2HP_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(next_offset), "stalled result changed")

  `L2HP_ASSERT(a_fail_zero, out_valid && status != ST_OK |-> header_length == 6'd0 && l3_kind == KIND_NONE, "failed result carries header fields")

  `L2HP_ASSERT(a_kind_len, out_valid && l3_kind != KIND_NONE |-> status == ST_OK && header_length != 6'd0, "layer-3 kind without a header")

  `L2HP_ASSERT(a_ready_free, !out_valid |-> in_ready, "input stalled with empty result slot")

endmodule

bind layer2_header_parser l2hp_checker u_l2hp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_s.ready),
  .out_valid     (out_m.valid),
  .out_ready     (out_m.ready),
  .status        (out_m.status),
  .header_length (out_m.header_length),
  .l3_kind       (out_m.l3_kind),
  .next_offset   (out_m.next_offset)
);
